// File: sv/gww_pkg.sv
`timescale 1ns / 1ps

package gww_pkg;

    localparam int CH_W       = 8;
    localparam int WRAP_W     = 6;
    localparam int CAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd1;

    localparam logic [WRAP_W-1:0] WRAP_RESET = 6'd40;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 16'hFFFF;

    localparam logic [CH_W-1:0] CH_NL  = 8'd10;
    localparam logic [CH_W-1:0] CH_TAB = 8'd9;
    localparam logic [CH_W-1:0] CH_SP  = 8'd32;

    typedef enum logic [1:0] {
        SEL_NL,
        SEL_SP,
        SEL_BUF,
        SEL_CHAR
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      latch_ww;
        logic      buf_wr;
        logic      stream_set;
        logic      stream_clr;
        logic      emit;
        emit_sel_t sel;
        logic      last;
        logic      idx_inc;
        logic      wl_clr;
        logic      mark;
    } cmd_t;

    typedef struct packed {
        logic is_eot;
        logic is_nl;
        logic is_blank;
        logic streaming;
        logic wl_zero;
        logic col_zero;
        logic overflow;
        logic col_full;
        logic buf_last;
        logic out_free;
    } stat_t;

    function automatic logic [WRAP_W-1:0] clamp_width(
        input logic [WRAP_W-1:0] w,
        input logic [WRAP_W-1:0] maxc
    );
        logic [WRAP_W-1:0] r;
        priority if (w == '0)
            r = WRAP_W'(1);
        else if (w > maxc)
            r = maxc;
        else
            r = w;
        return r;
    endfunction

endpackage

// File: sv/gww_in_if.sv
`timescale 1ns / 1ps

interface gww_in_if;
    logic                     valid;
    logic                     ready;
    logic [gww_pkg::CH_W-1:0] ch;
    logic                     end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

// File: sv/gww_out_if.sv
`timescale 1ns / 1ps

interface gww_out_if;
    logic                     valid;
    logic                     ready;
    logic [gww_pkg::CH_W-1:0] out_char;
    logic                     char_valid;
    logic                     last_of_run;
    logic                     done_res;
    logic                     failed;

    modport source (
        output valid, output out_char, output char_valid, output last_of_run,
        output done_res, output failed, input ready
    );
    modport sink (
        input valid, input out_char, input char_valid, input last_of_run,
        input done_res, input failed, output ready
    );
endinterface

// File: sv/gww_cfg_if.sv
`timescale 1ns / 1ps

interface gww_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gww_pkg::CFG_IDX_W-1:0]  index;
    logic [gww_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/gww_ctrl.sv
`timescale 1ns / 1ps

module gww_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gww_pkg::stat_t stat,
    output gww_pkg::cmd_t  cmd
);
    import gww_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPACE,
        ST_PRE_NL,
        ST_BUF,
        ST_CHAR,
        ST_NLCHAR,
        ST_MARK
    } state_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_NL,
        TAIL_MARK,
        TAIL_CHAR
    } tail_t;

    state_t state_reg, state_next;
    tail_t  tail_reg, tail_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        tail_next  = tail_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (stat.is_eot || stat.is_nl || stat.is_blank)
                    begin
                        cmd.stream_clr = 1'b1;
                        priority if (stat.is_eot)
                            tail_next = TAIL_MARK;
                        else if (stat.is_nl)
                            tail_next = TAIL_NL;
                        else
                            tail_next = TAIL_NONE;
                        if (!stat.wl_zero)
                            state_next = ST_SPACE;
                        else if (stat.is_eot)
                            state_next = ST_MARK;
                        else if (stat.is_nl)
                            state_next = ST_NLCHAR;
                        else
                            state_next = ST_IDLE;
                    end
                    else if (stat.streaming)
                    begin
                        state_next = ST_CHAR;
                    end
                    else
                    begin
                        cmd.latch_ww = stat.wl_zero;
                        priority if (stat.col_zero)
                        begin
                            cmd.stream_set = 1'b1;
                            state_next     = ST_CHAR;
                        end
                        else if (stat.overflow)
                        begin
                            cmd.stream_set = 1'b1;
                            tail_next      = TAIL_CHAR;
                            state_next     = ST_PRE_NL;
                        end
                        else
                        begin
                            cmd.buf_wr = 1'b1;
                        end
                    end
                end
            end
            ST_SPACE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_SP;
                    state_next = ST_BUF;
                end
            end
            ST_PRE_NL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_NL;
                    state_next = stat.wl_zero ? ST_CHAR : ST_BUF;
                end
            end
            ST_BUF:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.col_full)
                    begin
                        cmd.sel = SEL_NL;
                    end
                    else
                    begin
                        cmd.sel     = SEL_BUF;
                        cmd.idx_inc = 1'b1;
                        if (stat.buf_last)
                        begin
                            cmd.wl_clr = 1'b1;
                            cmd.last   = (tail_reg == TAIL_NONE);
                            unique case (tail_reg)
                                TAIL_NONE: state_next = ST_IDLE;
                                TAIL_NL:   state_next = ST_NLCHAR;
                                TAIL_MARK: state_next = ST_MARK;
                                TAIL_CHAR: state_next = ST_CHAR;
                                default:   state_next = ST_IDLE;
                            endcase
                        end
                    end
                end
            end
            ST_CHAR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.col_full)
                    begin
                        cmd.sel = SEL_NL;
                    end
                    else
                    begin
                        cmd.sel    = SEL_CHAR;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NLCHAR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_NL;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.mark   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tail_reg  <= TAIL_NONE;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

// File: sv/gww_datapath.sv
`timescale 1ns / 1ps

module gww_datapath #(
    parameter int COL_LIMIT = 40
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [gww_pkg::CH_W-1:0]       in_ch,
    input  logic                           in_eot,
    input  logic                           cfg_we,
    input  logic [gww_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gww_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gww_pkg::cmd_t                  cmd,
    output gww_pkg::stat_t                 stat,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [gww_pkg::CH_W-1:0]       out_char,
    output logic                           out_char_valid,
    output logic                           out_last,
    output logic                           out_done,
    output logic                           out_failed
);
    import gww_pkg::*;

    localparam int CW = $clog2(COL_LIMIT + 1);
    localparam int AW = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;
    localparam logic [WRAP_W-1:0] MAX_W = WRAP_W'(COL_LIMIT);

    logic [WRAP_W-1:0] wrap_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [CH_W-1:0]   ch_reg;
    logic              eot_reg;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     wl_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    logic [CW-1:0]     ww_reg;
    logic              stream_reg;
    logic [CAP_W-1:0]  count_reg;
    logic              fail_reg;
    logic [CH_W-1:0]   rd_reg;
    logic [CH_W-1:0]   store [COL_LIMIT];

    logic              out_valid_reg;
    logic [CH_W-1:0]   out_char_reg;
    logic              out_cv_reg;
    logic              out_last_reg;
    logic              out_done_reg;
    logic              out_failed_reg;

    logic [CW-1:0]     eff_w;
    logic [CW-1:0]     ww_cur;
    logic              can_emit;
    logic              near_cap;
    logic [CH_W-1:0]   emit_char;

    assign eff_w  = CW'(clamp_width(wrap_reg, MAX_W));
    assign ww_cur = (wl_reg == '0) ? eff_w : ww_reg;

    assign can_emit = !fail_reg && (count_reg < cap_reg);
    assign near_cap = ({1'b0, count_reg} + (CAP_W + 1)'(1)) >= {1'b0, cap_reg};

    assign idx_next = cmd.wl_clr  ? '0 :
                      cmd.idx_inc ? idx_reg + CW'(1) : idx_reg;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_NL:   emit_char = CH_NL;
            SEL_SP:   emit_char = CH_SP;
            SEL_BUF:  emit_char = rd_reg;
            SEL_CHAR: emit_char = ch_reg;
            default:  emit_char = CH_NL;
        endcase
    end

    always_comb
    begin
        stat.is_eot    = in_eot;
        stat.is_nl     = (in_ch == CH_NL);
        stat.is_blank  = (in_ch == CH_SP) || (in_ch == CH_TAB);
        stat.streaming = stream_reg;
        stat.wl_zero   = (wl_reg == '0);
        stat.col_zero  = (col_reg == '0);
        stat.overflow  = ({2'b00, col_reg} + {2'b00, wl_reg} + (CW + 2)'(2))
                         > {2'b00, ww_cur};
        stat.col_full  = (col_reg >= ww_reg);
        stat.buf_last  = ({1'b0, idx_reg} + (CW + 1)'(1)) == {1'b0, wl_reg};
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_wr)
            store[wl_reg[AW-1:0]] <= in_ch;
        rd_reg <= store[idx_next[AW-1:0]];
        if (cmd.load)
        begin
            ch_reg  <= in_ch;
            eot_reg <= in_eot;
        end
        if (cmd.emit && can_emit)
        begin
            out_char_reg   <= emit_char;
            out_cv_reg     <= 1'b1;
            // end-of-text items always close with the completion marker
            out_last_reg   <= cmd.last || (near_cap && !eot_reg);
            out_done_reg   <= 1'b0;
            out_failed_reg <= 1'b0;
        end
        else if (cmd.mark)
        begin
            out_char_reg   <= '0;
            out_cv_reg     <= 1'b0;
            out_last_reg   <= 1'b1;
            out_done_reg   <= 1'b1;
            out_failed_reg <= fail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg      <= WRAP_RESET;
            cap_reg       <= CAP_RESET;
            col_reg       <= '0;
            wl_reg        <= '0;
            idx_reg       <= '0;
            ww_reg        <= CW'(clamp_width(WRAP_RESET, MAX_W));
            stream_reg    <= 1'b0;
            count_reg     <= '0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WRAP: wrap_reg <= cfg_data[WRAP_W-1:0];
                    REG_CAP:  cap_reg  <= cfg_data[CAP_W-1:0];
                    default:  ;
                endcase
            end

            idx_reg <= idx_next;

            if (cmd.latch_ww)
                ww_reg <= eff_w;
            if (cmd.stream_set)
                stream_reg <= 1'b1;
            else if (cmd.stream_clr)
                stream_reg <= 1'b0;
            if (cmd.buf_wr)
                wl_reg <= wl_reg + CW'(1);
            else if (cmd.wl_clr)
                wl_reg <= '0;

            if (cmd.emit)
            begin
                col_reg <= (cmd.sel == SEL_NL) ? '0 : col_reg + CW'(1);
                if (can_emit)
                    count_reg <= count_reg + CAP_W'(1);
                else
                    fail_reg <= 1'b1;
            end

            if (cmd.mark)
            begin
                col_reg    <= '0;
                wl_reg     <= '0;
                idx_reg    <= '0;
                stream_reg <= 1'b0;
                count_reg  <= '0;
                fail_reg   <= 1'b0;
            end

            if ((cmd.emit && can_emit) || cmd.mark)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign out_char_valid = out_cv_reg;
    assign out_last       = out_last_reg;
    assign out_done       = out_done_reg;
    assign out_failed     = out_failed_reg;

endmodule

// File: sv/greedy_word_wrap_core.sv
`timescale 1ns / 1ps

// Channel    Dir  Payload                                           Transfer when
// text_in    in   ch[7:0], end_of_text                              valid && ready
// text_out   out  out_char[7:0], char_valid, last_of_run,
//                 done_res, failed                                  valid && ready
// cfg        in   index[1:0], data[15:0]                            valid && ready
//
// An item is taken while idle, then each output byte or marker is issued in turn,
// bytes dropped past capacity included; a word byte that is buffered or a blank with
// no pending word finishes in the accept cycle.
// Flushing a buffered word issues a space or line break, then its bytes with any
// breaks inserted, read one byte a cycle from the buffer unless text_out stalls.
// A stalled text_out holds the sequencer; the output register frees a slot.
// Reset is asynchronous; the word buffer is not cleared.

module greedy_word_wrap_core #(
    parameter int COL_LIMIT = 40
) (
    input logic     clk,
    input logic     rst_n,
    gww_in_if.sink  text_in,
    gww_out_if.source text_out,
    gww_cfg_if.sink cfg
);
    import gww_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    gww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gww_datapath #(
        .COL_LIMIT (COL_LIMIT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (text_in.ch),
        .in_eot         (text_in.end_of_text),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (text_out.ready),
        .out_valid      (text_out.valid),
        .out_char       (text_out.out_char),
        .out_char_valid (text_out.char_valid),
        .out_last       (text_out.last_of_run),
        .out_done       (text_out.done_res),
        .out_failed     (text_out.failed)
    );

endmodule

// File: sv/gww_checker.sv
`timescale 1ns / 1ps

module gww_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_eot,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [gww_pkg::CH_W-1:0] out_char,
    input logic                     out_cv,
    input logic                     out_last,
    input logic                     out_done,
    input logic                     out_failed
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_cv)
            && $stable(out_last) && $stable(out_done) && $stable(out_failed))
        else $error("stalled result changed");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_done |-> out_last && !out_cv && (out_char == '0))
        else $error("completion marker malformed");

    a_char_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_cv |-> !out_done && !out_failed)
        else $error("character result carries status");

    // end marker always produces a marker, so the block is busy next cycle
    a_eot_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_eot |=> !in_ready)
        else $error("input taken right after end marker");

endmodule

bind greedy_word_wrap_core gww_checker u_gww_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (text_in.valid),
    .in_ready   (text_in.ready),
    .in_eot     (text_in.end_of_text),
    .out_valid  (text_out.valid),
    .out_ready  (text_out.ready),
    .out_char   (text_out.out_char),
    .out_cv     (text_out.char_valid),
    .out_last   (text_out.last_of_run),
    .out_done   (text_out.done_res),
    .out_failed (text_out.failed)
);

// File: dv/gww_wrap_checker.sv
`timescale 1ns / 1ps

module gww_wrap_checker #(
    parameter int COL_LIMIT = 40
) (
    input  logic clk,
    input  logic rst_n,
    gww_in_if    text_in,
    gww_out_if   text_out,
    gww_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);
    import gww_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] out_char;
        logic            char_valid;
        logic            last_of_run;
        logic            done_res;
        logic            failed;
    } wrapped_t;

    wrapped_t wrapped_q[$];

    logic [WRAP_W-1:0] wrap_reg;
    logic [CAP_W-1:0]  cap_reg;

    logic [WRAP_W-1:0] column;
    logic [WRAP_W-1:0] word_len;
    logic [WRAP_W-1:0] word_width;
    logic [CH_W-1:0]   word_store [COL_LIMIT];
    logic              streaming;
    logic              over_flag;
    logic [CAP_W-1:0]  out_count;

    function automatic logic [WRAP_W-1:0] line_width(input logic [WRAP_W-1:0] w);
        logic [WRAP_W-1:0] r;
        r = w;
        if (w == '0)
            r = WRAP_W'(1);
        else if (int'(w) > COL_LIMIT)
            r = WRAP_W'(COL_LIMIT);
        return r;
    endfunction

    task put_result(input logic [CH_W-1:0] c, input logic cv, input logic done,
                    input logic fl);
        wrapped_t r;
        r.out_char    = c;
        r.char_valid  = cv;
        r.last_of_run = 1'b0;
        r.done_res    = done;
        r.failed      = fl;
        wrapped_q.push_back(r);
    endtask

    // capacity gate: once over, nothing more is emitted until end of text
    task emit_byte(input logic [CH_W-1:0] c);
        if (!over_flag) begin
            if (out_count >= cap_reg)
                over_flag = 1'b1;
            else begin
                out_count = out_count + 1'b1;
                put_result(c, 1'b1, 1'b0, 1'b0);
            end
        end
    endtask

    task place_byte(input logic [CH_W-1:0] c);
        if (column >= word_width) begin
            emit_byte(CH_NL);
            column = '0;
        end
        emit_byte(c);
        column = column + 1'b1;
    endtask

    task flush_word();
        int i;
        for (i = 0; i < int'(word_len) && i < COL_LIMIT; i++)
            place_byte(word_store[i]);
        word_len = '0;
    endtask

    task close_word();
        if (word_len != '0) begin
            emit_byte(CH_SP);
            column = column + 1'b1;
            flush_word();
        end
        streaming = 1'b0;
    endtask

    task clear_line_state();
        column    = '0;
        word_len  = '0;
        streaming = 1'b0;
        out_count = '0;
        over_flag = 1'b0;
    endtask

    task wrap_step(input logic [CH_W-1:0] c, input logic eot);
        int first;
        first = wrapped_q.size();
        if (eot) begin
            close_word();
            put_result('0, 1'b0, 1'b1, over_flag);
            clear_line_state();
        end else if (c == CH_NL) begin
            close_word();
            emit_byte(CH_NL);
            column = '0;
        end else if (c == CH_SP || c == CH_TAB) begin
            close_word();
        end else if (streaming) begin
            place_byte(c);
        end else begin
            if (word_len == '0)
                word_width = line_width(wrap_reg);
            if (column == '0) begin
                streaming = 1'b1;
                place_byte(c);
            end else if (int'(column) + 2 + int'(word_len) > int'(word_width)) begin
                emit_byte(CH_NL);
                column = '0;
                flush_word();
                streaming = 1'b1;
                place_byte(c);
            end else if (int'(word_len) < COL_LIMIT) begin
                word_store[word_len] = c;
                word_len = word_len + 1'b1;
            end
        end
        if (wrapped_q.size() > first)
            wrapped_q[wrapped_q.size()-1].last_of_run = 1'b1;
    endtask

    task check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task check_result();
        wrapped_t exp_r;
        if (wrapped_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none actual char %0h done %0b",
                     $time, text_out.out_char, text_out.done_res);
            fail_count++;
        end else begin
            exp_r = wrapped_q.pop_front();
            check_field("out_char", exp_r.out_char, text_out.out_char);
            check_field("char_valid", exp_r.char_valid, text_out.char_valid);
            check_field("last_of_run", exp_r.last_of_run, text_out.last_of_run);
            check_field("done_res", exp_r.done_res, text_out.done_res);
            check_field("failed", exp_r.failed, text_out.failed);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wrap_reg   = WRAP_RESET;
            cap_reg    = CAP_RESET;
            clear_line_state();
            word_width = line_width(WRAP_RESET);
            wrapped_q.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_WRAP: wrap_reg = cfg.data[WRAP_W-1:0];
                    REG_CAP:  cap_reg  = cfg.data[CAP_W-1:0];
                    default:  ;
                endcase
            end
            if (text_in.valid && text_in.ready)
                wrap_step(text_in.ch, text_in.end_of_text);
            if (text_out.valid && text_out.ready)
                check_result();
            pending = wrapped_q.size();
        end
    end

endmodule

// File: dv/tb_greedy_word_wrap_core.sv
`timescale 1ns / 1ps

module tb_greedy_word_wrap_core;
    import gww_pkg::*;

    localparam int MAX_COLS      = 40;
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 12;
    localparam int NUM_PHASES    = 6;

    // unmapped register index, written once to exercise the index bits
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    logic calm;
    int   items_sent;
    int   fail_count;
    int   pending;
    int   stall_cycles = 0;

    gww_in_if  text_in ();
    gww_out_if text_out ();
    gww_cfg_if cfg ();

    greedy_word_wrap_core #(
        .COL_LIMIT(MAX_COLS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .text_out(text_out),
        .cfg     (cfg)
    );

    gww_wrap_checker #(
        .COL_LIMIT(MAX_COLS)
    ) wrap_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .text_out  (text_out),
        .cfg       (cfg),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        text_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            text_out.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready) ||
                (cfg.valid && cfg.ready))
                stall_cycles = 0;
            else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic logic [CH_W-1:0] pick_word_byte();
        logic [CH_W-1:0] c;
        c = CH_W'($urandom_range(0, 255));
        while (c == CH_NL || c == CH_TAB || c == CH_SP)
            c = CH_W'($urandom_range(0, 255));
        return c;
    endfunction

    task push_item(input logic [CH_W-1:0] c, input logic eot);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            text_in.valid <= 1'b0;
            @(negedge clk);
        end
        text_in.valid       <= 1'b1;
        text_in.ch          <= c;
        text_in.end_of_text <= eot;
        @(posedge clk);
        while (!text_in.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task send_byte(input logic [CH_W-1:0] c);
        push_item(c, 1'b0);
    endtask

    task send_end();
        push_item(CH_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold the sender until every pending result has drained and the block is idle
    task settle();
        text_in.valid <= 1'b0;
        while (pending != 0 || !text_in.ready)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task random_text(input int target);
        int r;
        int len;
        int k;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 45) : $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                    send_byte(pick_word_byte());
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_byte(CH_SP);
                else if (r < 88)
                    repeat ($urandom_range(1, 3))
                        send_byte(($urandom_range(0, 1) == 1) ? CH_TAB : CH_SP);
                else
                    send_byte(CH_NL);
            end else if (r < 80) begin
                send_byte(CH_NL);
            end else if (r < 95) begin
                send_byte(CH_W'($urandom_range(0, 255)));
            end else begin
                send_end();
            end
        end
    endtask

    initial
    begin
        int p;
        logic [WRAP_W-1:0] w;
        logic [CAP_W-1:0] cap;

        rst_n               = 1'b0;
        calm                = 1'b0;
        items_sent          = 0;
        text_in.valid       = 1'b0;
        text_in.ch          = '0;
        text_in.end_of_text = 1'b0;
        cfg.valid           = 1'b0;
        cfg.index           = '0;
        cfg.data            = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty text, then blanks, odd bytes and newlines at reset widths
        send_end();
        send_byte(CH_SP);
        send_byte(CH_TAB);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_SP);
        send_byte(CH_TAB);
        send_byte(CH_SP);
        send_byte("a");
        send_byte(CH_TAB);
        send_byte("b");
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte("c");
        send_end();

        // zero width runs as one column
        settle();
        write_reg(REG_WRAP, 16'hFFC0);
        send_byte("a");
        send_byte("b");
        send_byte(CH_SP);
        send_byte("c");
        send_end();

        // width above the maximum, no capacity at all
        settle();
        write_reg(REG_WRAP, 16'h003F);
        write_reg(REG_CAP, 16'h0000);
        send_byte("x");
        send_end();

        // capacity runs out inside a word
        settle();
        write_reg(REG_CAP, 16'd3);
        send_byte("a");
        send_byte("b");
        send_byte(CH_SP);
        send_byte("c");
        send_byte("d");
        send_end();

        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin w = WRAP_W'($urandom_range(8, 20)); cap = CAP_RESET; end
                1: begin w = WRAP_W'(1); cap = CAP_W'($urandom_range(0, 65535)); end
                2: begin w = WRAP_W'($urandom_range(1, 40)); cap = CAP_W'($urandom_range(0, 24)); end
                3: begin w = WRAP_W'(40); cap = CAP_RESET; end
                4: begin w = WRAP_W'($urandom_range(41, 63)); cap = CAP_RESET; end
                default: begin w = WRAP_W'($urandom_range(2, 7)); cap = CAP_W'($urandom_range(25, 80)); end
            endcase
            write_reg(REG_WRAP, {10'($urandom()), w});
            write_reg(REG_CAP, cap);
            if (p == 2)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
            calm = (p == 3);
            random_text(items_sent + PHASE_ITEMS);
            // some phases end mid-word so the next width lands on a pending word
            if (p != 1 && p != 3)
                send_end();
        end

        calm = 1'b0;
        send_end();
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
